// ----- hdl/gppf_pkg.sv -----
// Shared types and constants for the prime pair finder.
package gppf_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_FOUND   = 2'd0;
  localparam status_t ST_NONE    = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture number, candidate = 2
    logic test_p;       // start primality test of candidate
    logic test_q;       // start primality test of number - candidate
    logic next_p;       // advance candidate and test it
    logic div_start;    // load divider with value under test
    logic div_step;     // one restoring-division bit
    logic f_next;       // advance trial factor
    logic res_found;
    logic res_none;
    logic res_invalid;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic invalid;      // odd or not above 2
    logic sq_gt_v;      // factor squared exceeds value: value is prime
    logic p_at_half;    // candidate reached number/2
    logic div_last;     // final division bit this cycle
    logic rem_zero;     // factor divides value
  } dp_sts_t;

endpackage

// ----- hdl/gppf_ctrl.sv -----
// Sequencer for the candidate search, trial factors and bit-serial divider.
module gppf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gppf_pkg::dp_cmd_t cmd,
  input  gppf_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TEST,
    S_DIV,
    S_REM,
    S_DONE
  } state_t;

  state_t state;
  logic   second;   // testing number - candidate

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = in_valid;
      S_CHECK: begin
        if (sts.invalid) cmd.res_invalid = 1'b1;
        else             cmd.test_p      = 1'b1;
      end
      S_TEST: begin
        if (sts.sq_gt_v) begin
          if (second) cmd.res_found = 1'b1;
          else        cmd.test_q    = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_REM: begin
        if (sts.rem_zero) begin
          if (sts.p_at_half) cmd.res_none = 1'b1;
          else               cmd.next_p   = 1'b1;
        end else begin
          cmd.f_next = 1'b1;
        end
      end
      S_DONE:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      second    <= 1'b0;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_CHECK;
            in_ready <= 1'b0;
          end
        end
        S_CHECK: begin
          second <= 1'b0;
          if (sts.invalid) begin
            state     <= S_DONE;
            out_valid <= 1'b1;
          end else begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (sts.sq_gt_v) begin
            if (second) begin
              state     <= S_DONE;
              out_valid <= 1'b1;
            end else begin
              second <= 1'b1;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (sts.div_last) state <= S_REM;
        end
        S_REM: begin
          if (sts.rem_zero) begin
            second <= 1'b0;
            if (sts.p_at_half) begin
              state     <= S_DONE;
              out_valid <= 1'b1;
            end else begin
              state <= S_TEST;
            end
          end else begin
            state <= S_TEST;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/gppf_dp.sv -----
// Datapath: number, candidate, trial factor with running square, restoring divider.
module gppf_dp #(
  parameter int NUMBER_BITS = 16
) (
  input  logic                   clk,
  input  logic [NUMBER_BITS-1:0] number,
  input  gppf_pkg::dp_cmd_t      cmd,
  output gppf_pkg::dp_sts_t      sts,
  output gppf_pkg::status_t      status,
  output logic [NUMBER_BITS-2:0] smaller_prime,
  output logic [NUMBER_BITS-1:0] larger_prime
);

  localparam int NB = NUMBER_BITS;
  localparam int CW = $clog2(NB);

  logic [NB-1:0] n;
  logic [NB-1:0] p;
  logic [NB-1:0] v;       // value under test
  logic [NB-1:0] f;       // trial factor
  logic [NB+1:0] sq;      // f*f
  logic [NB-1:0] dvd;
  logic [NB-1:0] rem;
  logic [CW-1:0] cnt;

  logic [NB-1:0] q;
  logic [NB-1:0] p_inc;
  logic [NB:0]   rem_sh;
  logic [NB:0]   rem_sub;

  assign q       = n - p;
  assign p_inc   = p + NB'(1);
  assign rem_sh  = {rem, dvd[NB-1]};
  assign rem_sub = rem_sh - {1'b0, f};

  assign sts.invalid   = (n <= NB'(2)) || n[0];
  assign sts.sq_gt_v   = sq > {2'b00, v};
  assign sts.p_at_half = (p == {1'b0, n[NB-1:1]});
  assign sts.div_last  = (cnt == '0);
  assign sts.rem_zero  = (rem == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= number;
      p <= NB'(2);
    end
    if (cmd.test_p || cmd.test_q || cmd.next_p) begin
      f  <= NB'(2);
      sq <= (NB+2)'(4);
    end
    if (cmd.test_p) v <= p;
    if (cmd.test_q) v <= q;
    if (cmd.next_p) begin
      p <= p_inc;
      v <= p_inc;
    end
    if (cmd.f_next) begin
      f  <= f + NB'(1);
      sq <= sq + (NB+2)'({f, 1'b1});
    end
    if (cmd.div_start) begin
      dvd <= v;
      rem <= '0;
      cnt <= CW'(NB-1);
    end
    if (cmd.div_step) begin
      dvd <= {dvd[NB-2:0], 1'b0};
      cnt <= cnt - CW'(1);
      if (rem_sh >= {1'b0, f}) rem <= rem_sub[NB-1:0];
      else                     rem <= rem_sh[NB-1:0];
    end
    if (cmd.res_found) begin
      status        <= gppf_pkg::ST_FOUND;
      smaller_prime <= p[NB-2:0];
      larger_prime  <= q;
    end
    if (cmd.res_none || cmd.res_invalid) begin
      status        <= cmd.res_none ? gppf_pkg::ST_NONE : gppf_pkg::ST_INVALID;
      smaller_prime <= '0;
      larger_prime  <= '0;
    end
  end

endmodule

// ----- hdl/goldbach_prime_pair_finder.sv -----
// Goldbach pair finder: one word in, one result word out per number.
// Search time is data dependent. Each trial factor runs S_TEST, the bit-serial
// remainder unit in S_DIV (one bit per cycle) and S_REM; a prime verdict adds an
// S_TEST step, each candidate restarts the factor loop, invalid numbers skip to S_DONE.
// Throughput: one number at a time; the next word is taken after the result is taken.
// Reset (rst, synchronous): controller returns to idle, no result pending.
module goldbach_prime_pair_finder #(
  parameter int NUMBER_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // [NUMBER_BITS-1:0] number
  input  logic [((NUMBER_BITS+7)/8)*8-1:0]        s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // [1:0] status, then smaller_prime (NUMBER_BITS-1), then larger_prime (NUMBER_BITS)
  output logic [((2*NUMBER_BITS+1+7)/8)*8-1:0]    m_tdata
);

  localparam int OUT_W = ((2*NUMBER_BITS+1+7)/8)*8;

  gppf_pkg::dp_cmd_t        cmd;
  gppf_pkg::dp_sts_t        sts;
  gppf_pkg::status_t        status;
  logic [NUMBER_BITS-2:0]   smaller_prime;
  logic [NUMBER_BITS-1:0]   larger_prime;

  gppf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gppf_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk           (clk),
    .number        (s_tdata[NUMBER_BITS-1:0]),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .smaller_prime (smaller_prime),
    .larger_prime  (larger_prime)
  );

  assign m_tdata = OUT_W'({larger_prime, smaller_prime, status});

endmodule

// ----- verif/goldbach_prime_pair_finder_test.sv -----
// Self-checking testbench for goldbach_prime_pair_finder: directed and random numbers.
module goldbach_prime_pair_finder_test;

  localparam int NB    = 16;
  localparam int IN_W  = ((NB + 7) / 8) * 8;
  localparam int OUT_W = ((2 * NB + 1 + 7) / 8) * 8;

  typedef struct packed {
    logic [NB-1:0]     number;
    gppf_pkg::status_t status;
    logic [NB-2:0]     smaller;
    logic [NB-1:0]     larger;
  } split_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  split_t      pending_splits[$];
  int          error_count = 0;
  int          numbers_sent = 0;
  int          found_count = 0;
  int          rejected_count = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  longint      cycle_count = 0;
  longint      cycle_limit = 200000;

  goldbach_prime_pair_finder #(.NUMBER_BITS(NB)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] number
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [1:0] status, [16:2] smaller_prime, [32:17] larger_prime
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Trial division; work tallies cycles spent by a bit-serial remainder unit.
  function automatic bit trial_prime(input int unsigned v, inout longint work);
    int unsigned f;
    work += 1;
    if (v < 2) return 1'b0;
    for (f = 2; f * f <= v; f++) begin
      work += NB + 2;
      if (v % f == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic split_t split_number(input logic [NB-1:0] n, inout longint work);
    split_t      r;
    int unsigned v;
    int unsigned p;
    v = 32'(n);
    r.number = n;
    r.status = gppf_pkg::ST_INVALID;
    r.smaller = '0;
    r.larger = '0;
    work += 8;
    if (v <= 2 || n[0]) return r;
    r.status = gppf_pkg::ST_NONE;
    for (p = 2; p <= v / 2 && r.status != gppf_pkg::ST_FOUND; p++) begin
      work += 4;
      if (trial_prime(p, work) && trial_prime(v - p, work)) begin
        r.status = gppf_pkg::ST_FOUND;
        r.smaller = p[NB-2:0];
        r.larger = NB'(v - p);
      end
    end
    return r;
  endfunction

  task automatic send_number(input logic [NB-1:0] n);
    split_t want;
    longint work;
    work = 0;
    want = split_number(n, work);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(n);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_splits.push_back(want);
    numbers_sent++;
    if (want.status == gppf_pkg::ST_FOUND) found_count++;
    if (want.status == gppf_pkg::ST_INVALID) rejected_count++;
    // generous allowance for the search itself plus receiver stalls
    cycle_limit += 4 * work + 2000;
  endtask

  // Output side: random backpressure, driven at the falling edge.
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    split_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_splits.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_tdata);
        error_count++;
      end else begin
        want = pending_splits.pop_front();
        if (m_tdata[1:0] !== want.status || m_tdata[NB:2] !== want.smaller ||
            m_tdata[2*NB:NB+1] !== want.larger || m_tdata[OUT_W-1:2*NB+1] !== '0) begin
          $display("%0t: number %0d: expected status %0d pair %0d + %0d,",
                   $time, want.number, want.status, want.smaller, want.larger);
          $display("    got status %0d pair %0d + %0d (word %h)",
                   m_tdata[1:0], m_tdata[NB:2], m_tdata[2*NB:NB+1], m_tdata);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_splits.size());
      $display("goldbach_prime_pair_finder_test: errors");
      $finish;
    end
  end

  // Odd numbers and those not above two.
  task automatic test_invalid_numbers();
    send_number(16'd0);
    send_number(16'd1);
    send_number(16'd2);
    send_number(16'd3);
    send_number(16'd32769);
    send_number(16'h5555);
    send_number(16'hFFFF);
  endtask

  // Four (pair at exactly half), small evens, and numbers whose first pair is unusually far out.
  task automatic test_pair_search();
    send_number(16'd4);
    send_number(16'd6);
    send_number(16'd8);
    send_number(16'd12);
    send_number(16'd30);
    send_number(16'd98);
    send_number(16'd992);
    send_number(16'd2642);
    send_number(16'd5372);
    send_number(16'd43532);
    send_number(16'd63274);
    send_number(16'd32768);
    send_number(16'hAAAA);
    send_number(16'hFFFE);
  endtask

  task automatic random_numbers(input int count);
    int          k;
    int unsigned pick;
    logic [NB-1:0] n;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) n = NB'($urandom_range(4, 65534) & 32'hFFFE);
      else if (pick < 80) n = NB'($urandom_range(2, 600) * 2);
      else n = NB'($urandom_range(0, 65535));
      send_number(n);
    end
  endtask

  task automatic test_random_sender_idle();
    src_idle_pct = 33;
    sink_idle_pct = 87;
    random_numbers(27);
  endtask

  task automatic test_random_receiver_idle();
    src_idle_pct = 87;
    sink_idle_pct = 33;
    random_numbers(26);
  endtask

  task automatic test_random_full_rate();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    random_numbers(26);
  endtask

  initial begin
    src_idle_pct = 33;
    sink_idle_pct = 87;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_invalid_numbers();
    test_pair_search();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_full_rate();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Checked %0d numbers: %0d split into a prime pair,", numbers_sent, found_count);
    $display("%0d rejected as odd or too small, under sender-heavy, receiver-heavy",
             rejected_count);
    $display("and back-to-back handshake idling.");
    if (error_count == 0)
      $display("goldbach_prime_pair_finder_test: clean");
    else
      $display("goldbach_prime_pair_finder_test: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/gppf_pkg.sv
hdl/gppf_ctrl.sv
hdl/gppf_dp.sv
hdl/goldbach_prime_pair_finder.sv
verif/goldbach_prime_pair_finder_test.sv
